FILE: rtl/hpmc_pkg.sv
// ----------------------------------------------------------------------------
// hpmc_pkg
// Shared types and constants for the half-pel motion compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package hpmc_pkg;

  localparam int LANES     = 16;  // pixels per wide row (8..16)
  localparam int MAX_ROWS  = 16;  // tallest block
  localparam int ROW_PIX   = 17;  // reference pixels per row
  localparam int PIX_W     = 8;
  localparam int OUT_PIX   = 16;  // pixels carried by pred_lo and pred_hi
  localparam int NARROW_PIX = 8;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int HEIGHT_W   = 5;

  typedef enum logic [1:0] {
    MODE_FULL  = 2'd0,
    MODE_HORIZ = 2'd1,
    MODE_VERT  = 2'd2,
    MODE_DIAG  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 4'd0,
    REG_AVG    = 4'd1,
    REG_WIDE   = 4'd2,
    REG_HEIGHT = 4'd3
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

  // per-lane control, common to every lane
  typedef struct packed {
    mode_t mode;
    logic  avg;
  } lane_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/hpmc_lane.sv
// ----------------------------------------------------------------------------
// hpmc_lane
// One pixel of half-pel interpolation with optional averaging against the
// existing prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module hpmc_lane (
  input  wire hpmc_pkg::pix_t       a,     // current row, this column
  input  wire hpmc_pkg::pix_t       b,     // current row, right neighbor
  input  wire hpmc_pkg::pix_t       p,     // previous row, this column
  input  wire hpmc_pkg::pix_t       q,     // previous row, right neighbor
  input  wire hpmc_pkg::pix_t       old,
  input  wire hpmc_pkg::lane_ctrl_t ctrl,
  output hpmc_pkg::pix_t            res
);

  logic [9:0] sum_h;
  logic [9:0] sum_v;
  logic [9:0] sum_d;
  logic [7:0] interp;
  logic [8:0] sum_avg;

  always_comb begin
    sum_h = {2'b0, a} + {2'b0, b} + 10'd1;
    sum_v = {2'b0, p} + {2'b0, a} + 10'd1;
    sum_d = {2'b0, p} + {2'b0, q} + {2'b0, a} + {2'b0, b} + 10'd2;
    case (ctrl.mode)
      hpmc_pkg::MODE_FULL:  interp = a;
      hpmc_pkg::MODE_HORIZ: interp = sum_h[8:1];
      hpmc_pkg::MODE_VERT:  interp = sum_v[8:1];
      hpmc_pkg::MODE_DIAG:  interp = sum_d[9:2];
      default:              interp = a;
    endcase
    sum_avg = {1'b0, interp} + {1'b0, old} + 9'd1;
    res = ctrl.avg ? sum_avg[8:1] : interp;
  end

endmodule

`default_nettype wire

FILE: rtl/hpmc_merge.sv
// ----------------------------------------------------------------------------
// hpmc_merge
// Packs the lane results into the two output words, blanking lanes that are
// not part of the current block width.
// ----------------------------------------------------------------------------
`default_nettype none

module hpmc_merge (
  input  wire [hpmc_pkg::OUT_PIX-1:0][hpmc_pkg::PIX_W-1:0] lane_res,
  input  wire                                                wide,
  output logic [63:0]                                        pred_lo,
  output logic [63:0]                                        pred_hi
);

  logic [hpmc_pkg::OUT_PIX-1:0][hpmc_pkg::PIX_W-1:0] masked;

  always_comb begin
    for (int i = 0; i < hpmc_pkg::OUT_PIX; i++) begin
      if (i < hpmc_pkg::NARROW_PIX || (wide && i < hpmc_pkg::LANES)) begin
        masked[i] = lane_res[i];
      end else begin
        masked[i] = '0;
      end
    end
    pred_lo = masked[7:0];
    pred_hi = masked[15:8];
  end

endmodule

`default_nettype wire

FILE: rtl/half_pel_motion_comp.sv
// ----------------------------------------------------------------------------
// half_pel_motion_comp
// Half-pel motion compensation: at most one prediction row per 17-pixel reference
// row, full/horizontal/vertical/diagonal interpolation, optional averaging.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid / in_stall    | ref_lo, ref_hi, ref_extra, old_pred_*
//  out     | out_valid / out_stall  | pred_lo, pred_hi, last_row
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one row per cycle while in_stall is low: 16 lanes compute the row while it is
// offered and the accepting edge loads the output register, so the result is offered from
// the next cycle on.
// in_stall is raised only while the output register holds a row that is stalled.
// in vertical and diagonal modes the first row of a block gives no transaction.
// synchronous reset loads register defaults, clears row store and row counter.
// ----------------------------------------------------------------------------
`default_nettype none

module half_pel_motion_comp (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [63:0] ref_lo,
  input  wire  [63:0] ref_hi,
  input  wire  [7:0]  ref_extra,
  input  wire  [63:0] old_pred_lo,
  input  wire  [63:0] old_pred_hi,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [63:0] pred_lo,
  output logic [63:0] pred_hi,
  output logic        last_row,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [hpmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [hpmc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int HW = hpmc_pkg::HEIGHT_W;

  hpmc_pkg::mode_t half_pel_mode;
  logic            avg_enable;
  logic            wide_block;
  logic [HW-1:0]   block_height;

  logic [hpmc_pkg::ROW_PIX-1:0][hpmc_pkg::PIX_W-1:0] prev_row;
  logic [HW-1:0]   row_count;
  logic [HW-1:0]   row_count_next;

  logic [hpmc_pkg::ROW_PIX-1:0][hpmc_pkg::PIX_W-1:0] cur;
  logic [hpmc_pkg::OUT_PIX-1:0][hpmc_pkg::PIX_W-1:0] old;
  logic [hpmc_pkg::OUT_PIX-1:0][hpmc_pkg::PIX_W-1:0] lane_res;
  hpmc_pkg::lane_ctrl_t ctrl;

  logic          accept;
  logic          vert;
  logic          load_only;
  logic          last;
  logic [HW-1:0] height;
  logic [HW:0]   rc_inc;
  logic [63:0]   merged_lo;
  logic [63:0]   merged_hi;

  assign cur  = {ref_extra, ref_hi, ref_lo};
  assign old  = {old_pred_hi, old_pred_lo};
  assign ctrl = '{mode: half_pel_mode, avg: avg_enable};

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  for (genvar i = 0; i < hpmc_pkg::OUT_PIX; i++) begin : g_lane
    hpmc_lane u_lane (
      .a    (cur[i]),
      .b    (cur[i+1]),
      .p    (prev_row[i]),
      .q    (prev_row[i+1]),
      .old  (old[i]),
      .ctrl (ctrl),
      .res  (lane_res[i])
    );
  end

  hpmc_merge u_merge (
    .lane_res (lane_res),
    .wide     (wide_block),
    .pred_lo  (merged_lo),
    .pred_hi  (merged_hi)
  );

  // row bookkeeping
  always_comb begin
    if (block_height == '0) begin
      height = HW'(1);
    end else if (block_height > HW'(hpmc_pkg::MAX_ROWS)) begin
      height = HW'(hpmc_pkg::MAX_ROWS);
    end else begin
      height = block_height;
    end
    vert      = (half_pel_mode == hpmc_pkg::MODE_VERT) ||
                (half_pel_mode == hpmc_pkg::MODE_DIAG);
    load_only = vert && (row_count == '0);
    rc_inc    = {1'b0, row_count} + (HW+1)'(1);
    if (vert) begin
      last = {1'b0, row_count} >= {1'b0, height};
    end else begin
      last = rc_inc >= {1'b0, height};
    end
    if (load_only) begin
      row_count_next = HW'(1);
    end else if (last) begin
      row_count_next = '0;
    end else begin
      row_count_next = rc_inc[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_pel_mode <= hpmc_pkg::MODE_FULL;
      avg_enable    <= 1'b0;
      wide_block    <= 1'b1;
      block_height  <= HW'(hpmc_pkg::MAX_ROWS);
      prev_row      <= '0;
      row_count     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          hpmc_pkg::REG_MODE:   half_pel_mode <= hpmc_pkg::mode_t'(cfg_data[1:0]);
          hpmc_pkg::REG_AVG:    avg_enable    <= cfg_data[0];
          hpmc_pkg::REG_WIDE:   wide_block    <= cfg_data[0];
          hpmc_pkg::REG_HEIGHT: block_height  <= cfg_data[HW-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        prev_row  <= cur;
        row_count <= row_count_next;
        if (!load_only) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  // output payload, loaded only with a produced row
  always_ff @(posedge clk) begin
    if (accept && !load_only) begin
      pred_lo  <= merged_lo;
      pred_hi  <= merged_hi;
      last_row <= last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hpmc_checker.sv
// ----------------------------------------------------------------------------
// hpmc_checker
// Port-level checks on the half-pel motion compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

module hpmc_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [63:0] pred_lo,
  input wire [63:0] pred_hi,
  input wire        last_row
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out transaction dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pred_lo) && $stable(pred_hi) && $stable(last_row))
    else $error("out payload changed while stalled");

  // input backpressure only comes from a held output
  a_in_stall_src: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind half_pel_motion_comp hpmc_checker u_hpmc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pred_lo   (pred_lo),
  .pred_hi   (pred_hi),
  .last_row  (last_row)
);

`default_nettype wire

FILE: test/tb_half_pel_motion_comp.sv
// ----------------------------------------------------------------------------
// tb_half_pel_motion_comp
// Self-checking bench for the half-pel motion compensation block. Reference
// rows are streamed under every mode, averaging, width and height setting,
// including out-of-range heights. An in-bench row predictor keeps its own
// row store and row counter. Every output row is checked against it.
// ----------------------------------------------------------------------------
module tb_half_pel_motion_comp;
  timeunit 1ns;
  timeprecision 1ps;

  import hpmc_pkg::*;

  localparam int TOTAL_ROWS = 1050;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_REPORTS = 200;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd9;  // decodes to no register

  typedef struct {
    logic [63:0] ref_lo, ref_hi;
    logic [7:0]  ref_extra;
    logic [63:0] old_lo, old_hi;
  } ref_row_t;

  typedef struct {
    logic [63:0] lo, hi;
    logic        last;
  } pred_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] ref_lo = '0;
  logic [63:0] ref_hi = '0;
  logic [7:0]  ref_extra = '0;
  logic [63:0] old_pred_lo = '0;
  logic [63:0] old_pred_hi = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] pred_lo;
  logic [63:0] pred_hi;
  logic        last_row;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the block's registers and state
  mode_t      set_mode = MODE_FULL;
  logic       set_avg = 1'b0;
  logic       set_wide = 1'b1;
  logic [4:0] set_height = 5'd16;
  pix_t       row_store[ROW_PIX] = '{default: '0};
  logic [4:0] rows_in_block = '0;

  ref_row_t  ref_rows[$];
  pred_row_t pending_preds[$];

  bit in_taken = 1'b0;
  bit no_idle = 1'b0;
  int send_gap = 0;
  int rx_left = 0;
  int out_hold_left = 0;
  int fail_count = 0;
  int rows_queued = 0;

  half_pel_motion_comp i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .ref_lo      (ref_lo),
    .ref_hi      (ref_hi),
    .ref_extra   (ref_extra),
    .old_pred_lo (old_pred_lo),
    .old_pred_hi (old_pred_hi),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pred_lo     (pred_lo),
    .pred_hi     (pred_hi),
    .last_row    (last_row),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicts the row for the reference row now on the input ports
  function automatic void interp_row();
    pix_t        cur[ROW_PIX];
    pix_t        old[OUT_PIX];
    logic [63:0] res_lo;
    logic [63:0] res_hi;
    int          height;
    int          lanes;
    int          r;
    int          k;
    logic        two_row;
    logic        last;
    height = (set_height == 0) ? 1 : (set_height > MAX_ROWS) ? MAX_ROWS : int'(set_height);
    lanes = set_wide ? LANES : NARROW_PIX;
    two_row = (set_mode == MODE_VERT) || (set_mode == MODE_DIAG);
    for (k = 0; k < 8; k++) begin
      cur[k] = ref_lo[8*k +: 8];
      cur[k+8] = ref_hi[8*k +: 8];
      old[k] = old_pred_lo[8*k +: 8];
      old[k+8] = old_pred_hi[8*k +: 8];
    end
    cur[16] = ref_extra;
    // first row of a two-row block only fills the store
    if (two_row && rows_in_block == 0) begin
      row_store = cur;
      rows_in_block = 5'd1;
      return;
    end
    res_lo = '0;
    res_hi = '0;
    for (k = 0; k < lanes; k++) begin
      case (set_mode)
        MODE_FULL:  r = int'(cur[k]);
        MODE_HORIZ: r = (int'(cur[k]) + int'(cur[k+1]) + 1) >> 1;
        MODE_VERT:  r = (int'(row_store[k]) + int'(cur[k]) + 1) >> 1;
        default:    r = (int'(row_store[k]) + int'(row_store[k+1]) + int'(cur[k])
                         + int'(cur[k+1]) + 2) >> 2;
      endcase
      if (set_avg) r = (r + int'(old[k]) + 1) >> 1;
      if (k < 8) res_lo[8*k +: 8] = r[7:0];
      else res_hi[8*(k-8) +: 8] = r[7:0];
    end
    // >= so a height lowered mid-block still ends it
    last = two_row ? (int'(rows_in_block) >= height) : (int'(rows_in_block) + 1 >= height);
    rows_in_block = last ? 5'd0 : rows_in_block + 5'd1;
    row_store = cur;
    pending_preds.push_back('{res_lo, res_hi, last});
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] corner_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      3: return 8'hFE;
      4: return 8'h80;
      default: return 8'h7F;
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    int          pick;
    int          k;
    pick = $urandom_range(0, 19);
    w = {$urandom, $urandom};
    if (pick < 3) begin
      for (k = 0; k < 8; k++) w[8*k +: 8] = corner_byte();
    end else if (pick == 3) begin
      w = '0;
    end else if (pick == 4) begin
      w = '1;
    end
    return w;
  endfunction

  function automatic ref_row_t make_row();
    ref_row_t row;
    row.ref_lo = rand_word();
    row.ref_hi = rand_word();
    row.ref_extra = ($urandom_range(0, 3) == 0) ? corner_byte() : 8'($urandom);
    row.old_lo = rand_word();
    row.old_hi = rand_word();
    return row;
  endfunction

  // fixed patterns for the directed rows: extremes and rounding edges
  function automatic ref_row_t pattern_row(int k);
    ref_row_t row;
    case (k % 5)
      0: row = '{64'h0, 64'h0, 8'h00, 64'h0, 64'h0};
      1: row = '{'1, '1, 8'hFF, '1, '1};
      2: row = '{'1, '1, 8'hFF, 64'h0, 64'h0};
      3: row = '{64'hFF00FF00FF00FF00, 64'hFF00FF00FF00FF00, 8'hFF,
                 64'h00FF00FF00FF00FF, 64'h00FF00FF00FF00FF};
      default: row = '{64'h0101010101010101, 64'h0001000100010001, 8'h00,
                       64'h0, 64'h0100010001000100};
    endcase
    return row;
  endfunction

  // result side: compare first, then take a new input transaction
  always @(posedge clk) begin : monitor
    pred_row_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_preds.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $error("unexpected result transaction: pred_lo=%h pred_hi=%h", pred_lo, pred_hi);
        fail_count++;
      end else begin
        want = pending_preds.pop_front();
        if (pred_lo !== want.lo) begin
          if (fail_count < MAX_REPORTS)
            $error("pred_lo mismatch: expected %h, actual %h", want.lo, pred_lo);
          fail_count++;
        end
        if (pred_hi !== want.hi) begin
          if (fail_count < MAX_REPORTS)
            $error("pred_hi mismatch: expected %h, actual %h", want.hi, pred_hi);
          fail_count++;
        end
        if (last_row !== want.last) begin
          if (fail_count < MAX_REPORTS)
            $error("last_row mismatch: expected %b, actual %b", want.last, last_row);
          fail_count++;
        end
      end
    end
    if (!rst && in_valid && !in_stall) begin
      in_taken = 1'b1;
      interp_row();
    end
  end

  always @(negedge clk) begin : driver
    ref_row_t row;
    if (!rst && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (ref_rows.size() > 0) begin
        row = ref_rows.pop_front();
        ref_lo <= row.ref_lo;
        ref_hi <= row.ref_hi;
        ref_extra <= row.ref_extra;
        old_pred_lo <= row.old_lo;
        old_pred_hi <= row.old_hi;
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    bit stall_now;
    if (out_hold_left > 0) begin
      out_stall <= 1'b1;
      out_hold_left--;
      rx_left = 0;
    end else if (rx_left > 0) begin
      rx_left--;
    end else begin
      stall_now = !no_idle && ($urandom_range(0, 2) == 0);
      out_stall <= stall_now;
      rx_left = stall_now ? pick_gap() : $urandom_range(0, 6);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:   set_mode = mode_t'(val[1:0]);
      REG_AVG:    set_avg = val[0];
      REG_WIDE:   set_wide = val[0];
      REG_HEIGHT: set_height = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // rows without a result may still be in flight, hence the extra cycles
  task automatic wait_drained();
    while (ref_rows.size() != 0 || in_valid || pending_preds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_rows(input int n_rows, input bit burst, input int hold);
    int k;
    no_idle = burst;
    for (k = 0; k < n_rows; k++) ref_rows.push_back(make_row());
    rows_queued += n_rows;
    if (hold > 0) begin
      repeat (6) @(posedge clk);
      out_hold_left = hold;
    end
    wait_drained();
  endtask

  initial begin : stimulus
    int         phase;
    int         k;
    int         eff;
    int         blk;
    int         n_rows;
    mode_t      mode;
    logic       avg;
    logic       wide;
    logic [4:0] height;
    int         fixed_height[4];
    fixed_height = '{0, 31, 16, 1};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: every mode with and without averaging, short blocks
    for (phase = 0; phase < 8; phase++) begin
      write_reg(REG_MODE, {6'd0, 2'(phase >> 1)});
      write_reg(REG_AVG, {7'd0, 1'(phase)});
      write_reg(REG_WIDE, {7'd0, ~1'(phase)});
      write_reg(REG_HEIGHT, 8'd2);
      for (k = 0; k < 3; k++) ref_rows.push_back(pattern_row(3 * phase + k));
      rows_queued += 3;
      wait_drained();
    end
    write_reg(REG_SPARE, 8'($urandom));

    phase = 0;
    while (rows_queued < 24 + TOTAL_ROWS) begin
      mode = mode_t'($urandom_range(0, 3));
      avg = 1'($urandom);
      wide = 1'($urandom);
      case ($urandom_range(0, 9))
        0, 1: height = 5'd4;
        2, 3: height = 5'd8;
        4, 5: height = 5'd16;
        6: height = 5'd0;
        7: height = 5'($urandom_range(17, 31));
        default: height = 5'($urandom_range(1, 31));
      endcase
      if (phase < 4) height = 5'(fixed_height[phase]);

      if (phase < 4 || $urandom_range(0, 3) != 0) write_reg(REG_MODE, {6'($urandom), mode});
      if (phase < 4 || $urandom_range(0, 3) != 0) write_reg(REG_AVG, {7'($urandom), avg});
      if (phase < 4 || $urandom_range(0, 3) != 0) write_reg(REG_WIDE, {7'($urandom), wide});
      if (phase < 4 || $urandom_range(0, 3) != 0)
        write_reg(REG_HEIGHT, {3'($urandom), height});
      if ($urandom_range(0, 15) == 0) write_reg(REG_SPARE, 8'($urandom));

      eff = (set_height == 0) ? 1 : (set_height > MAX_ROWS) ? MAX_ROWS : int'(set_height);
      blk = eff + ((set_mode == MODE_VERT || set_mode == MODE_DIAG) ? 1 : 0);
      if ($urandom_range(0, 3) == 0) n_rows = $urandom_range(1, 2 * blk);
      else n_rows = blk * $urandom_range(1, 3);

      // long receiver hold so the block backs up into its input
      if (phase == 5 || phase == 19) begin
        if (n_rows < 40) n_rows = 40;
        run_rows(n_rows, 1'b1, HOLD_CYCLES);
      end else begin
        run_rows(n_rows, $urandom_range(0, 3) == 0, 0);
      end
      phase++;
    end

    repeat (10) @(posedge clk);
    if (pending_preds.size() != 0) begin
      $error("%0d expected results never arrived", pending_preds.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/hpmc_pkg.sv
rtl/hpmc_lane.sv
rtl/hpmc_merge.sv
rtl/half_pel_motion_comp.sv
rtl/hpmc_checker.sv
test/tb_half_pel_motion_comp.sv
